// File: design/rct_pkg.sv
// Package with shared constants and types for the reversible color transform.
`default_nettype none

package rct_pkg;

    // Default sample width of one color channel.
    localparam int SAMPLE_BITS_DEF = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR  = 2'd1;

    // Transform kinds; the remaining code passes the pixel through.
    localparam logic [1:0] KIND_RCT  = 2'd0;
    localparam logic [1:0] KIND_LIFT = 2'd1;
    localparam logic [1:0] KIND_SUBG = 2'd2;

    // Active transform settings handed to the datapath.
    typedef struct packed {
        logic [1:0] kind;
        logic       inverse;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/rct_in_if.sv
// Input pixel channel: valid, ready and the three channels with the last flag.
`default_nettype none

interface rct_in_if import rct_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] chan0;
    logic signed [W-1:0] chan1;
    logic signed [W-1:0] chan2;
    logic                last_in;

    modport source (output valid, output chan0, output chan1, output chan2,
                    output last_in, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2,
                    input last_in, output ready);
endinterface

`default_nettype wire

// File: design/rct_out_if.sv
// Result pixel channel: valid, ready and the three channels with the last flag.
`default_nettype none

interface rct_out_if import rct_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out0;
    logic signed [W-1:0] out1;
    logic signed [W-1:0] out2;
    logic                last_out;

    modport source (output valid, output out0, output out1, output out2,
                    output last_out, input ready);
    modport sink   (input valid, input out0, input out1, input out2,
                    input last_out, output ready);
endinterface

`default_nettype wire

// File: design/rct_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
`default_nettype none

interface rct_cfg_if import rct_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/rct_xform.sv
// Combinational forward and inverse color transforms for one pixel.
`default_nettype none

module rct_xform import rct_pkg::*; #(
    parameter int W = SAMPLE_BITS_DEF
) (
    input  t_cfg                i_cfg,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic signed [W-1:0] i_c,
    output logic signed [W-1:0] o_0,
    output logic signed [W-1:0] o_1,
    output logic signed [W-1:0] o_2
);

    // Arithmetic half of a sample; it always fits the sample width.
    function automatic logic signed [W-1:0] half(input logic signed [W-1:0] v);
        return v >>> 1;
    endfunction

    // Quarter of a full-precision sum; only the stored result wraps.
    function automatic logic signed [W-1:0] quarter_sum(input logic signed [W-1:0] x,
                                                         input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = {x[W-1], x} + {y[W-1], y};
        s = s >>> 2;
        return s[W-1:0];
    endfunction

    logic signed [W-1:0] t_r;
    logic signed [W-1:0] t_g;
    logic signed [W-1:0] t_bl;
    logic signed [W-1:0] t_g2;

    // Every assignment to a sample-wide variable wraps in two's complement.
    always_comb begin
        t_r  = i_a;
        t_g  = i_b;
        t_bl = i_c;
        t_g2 = i_b;
        o_0  = i_a;
        o_1  = i_b;
        o_2  = i_c;
        case (i_cfg.kind)
            KIND_RCT: begin
                if (!i_cfg.inverse) begin
                    t_r  = i_a - i_b;
                    t_bl = i_c - i_b;
                    t_g  = i_b + quarter_sum(t_r, t_bl);
                    o_0  = t_g;
                    o_1  = t_bl;
                    o_2  = t_r;
                end else begin
                    // Input order is Y, Cb, Cr.
                    t_g  = i_a - quarter_sum(i_c, i_b);
                    t_bl = i_b + t_g;
                    t_r  = i_c + t_g;
                    o_0  = t_r;
                    o_1  = t_g;
                    o_2  = t_bl;
                end
            end
            KIND_LIFT: begin
                if (!i_cfg.inverse) begin
                    t_r  = i_a - i_b;
                    t_g  = i_b + half(t_r);
                    t_bl = i_c - t_g;
                    t_g2 = t_g + half(t_bl);
                end else begin
                    t_g  = i_b - half(i_c);
                    t_bl = i_c + t_g;
                    t_g2 = t_g - half(i_a);
                    t_r  = i_a + t_g2;
                end
                o_0 = t_r;
                o_1 = t_g2;
                o_2 = t_bl;
            end
            KIND_SUBG: begin
                if (!i_cfg.inverse) begin
                    o_0 = i_b;
                    o_1 = i_c - i_b;
                    o_2 = i_a - i_b;
                end else begin
                    // Input order is G, B difference, R difference.
                    o_0 = i_c + i_a;
                    o_1 = i_a;
                    o_2 = i_b + i_a;
                end
            end
            default: begin
                o_0 = i_a;
                o_1 = i_b;
                o_2 = i_c;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/reversible_color_transform.sv
// Top level of the reversible color transform: config registers and pixel pipeline.
//
//  Channel  | Dir  | Payload                               | Accepted when
//  i_pix    | in   | chan0, chan1, chan2, last_in          | valid && ready
//  o_pix    | out  | out0, out1, out2, last_out            | valid && ready
//  i_cfg    | in   | index (0 kind, 1 direction), data     | valid && ready
//
// One pixel per cycle while the result is taken; each accepted pixel passes through
// the input register, then the transform into the result register.
// Reset is synchronous and active low; it clears both pipeline valid flags and
// sets the transform to forward JPEG2000 RCT. The config port is always ready.
// When the result is not taken, the pipeline holds and input ready falls once
// both stages are full.
`default_nettype none

module reversible_color_transform import rct_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rct_in_if.sink    i_pix,
    rct_out_if.source o_pix,
    rct_cfg_if.sink   i_cfg
);

    t_cfg r_cfg;

    logic                          r_v1;
    logic signed [SAMPLE_BITS-1:0] r_a1;
    logic signed [SAMPLE_BITS-1:0] r_b1;
    logic signed [SAMPLE_BITS-1:0] r_c1;
    logic                          r_last1;

    logic                          r_v2;
    logic signed [SAMPLE_BITS-1:0] r_o0;
    logic signed [SAMPLE_BITS-1:0] r_o1;
    logic signed [SAMPLE_BITS-1:0] r_o2;
    logic                          r_last2;

    logic signed [SAMPLE_BITS-1:0] n_o0;
    logic signed [SAMPLE_BITS-1:0] n_o1;
    logic signed [SAMPLE_BITS-1:0] n_o2;

    logic s2_load;
    logic in_take;

    // Configuration writes; unknown indexes are ignored.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_KIND: r_cfg.kind    <= i_cfg.data[1:0];
                REG_DIR:  r_cfg.inverse <= i_cfg.data[0];
                default:  r_cfg         <= r_cfg;
            endcase
        end
    end

    // Pipeline handshake: the result stage loads when empty or being drained.
    assign s2_load     = !r_v2 || o_pix.ready;
    assign i_pix.ready = !r_v1 || s2_load;
    assign in_take     = i_pix.valid && i_pix.ready;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_pix.ready) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a1    <= i_pix.chan0;
            r_b1    <= i_pix.chan1;
            r_c1    <= i_pix.chan2;
            r_last1 <= i_pix.last_in;
        end
    end

    // Transform datapath between the two register stages.
    rct_xform #(
        .W (SAMPLE_BITS)
    ) u_xform (
        .i_cfg (r_cfg),
        .i_a   (r_a1),
        .i_b   (r_b1),
        .i_c   (r_c1),
        .o_0   (n_o0),
        .o_1   (n_o1),
        .o_2   (n_o2)
    );

    // Result register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_load) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && r_v1) begin
            r_o0    <= n_o0;
            r_o1    <= n_o1;
            r_o2    <= n_o2;
            r_last2 <= r_last1;
        end
    end

    assign o_pix.valid    = r_v2;
    assign o_pix.out0     = r_o0;
    assign o_pix.out1     = r_o1;
    assign o_pix.out2     = r_o2;
    assign o_pix.last_out = r_last2;

    // An accepted item always occupies the input stage on the next cycle.
    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_v1)
        else $error("accepted item did not reach the input stage");

    // An empty input stage never refuses an item.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_pix.ready)
        else $error("input refused while input stage empty");

    // Both stages full and output stalled blocks new items.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && !o_pix.ready) |-> !i_pix.ready)
        else $error("input accepted while pipeline full and stalled");

    // The last flag moves with its pixel into the result stage.
    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && s2_load) |=> (r_v2 && o_pix.last_out == $past(r_last1)))
        else $error("last flag lost between stages");

endmodule

`default_nettype wire
